[hdl/deq_pkg.sv]
// shared types and codes for the double-ended queue
package deq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // operations broadcast to the cell row
  localparam logic [1:0] OP_HOLD       = 2'd0;
  localparam logic [1:0] OP_SHIFT_UP   = 2'd1;
  localparam logic [1:0] OP_SHIFT_DOWN = 2'd2;
  localparam logic [1:0] OP_LOAD       = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  typedef struct packed {
    logic [1:0] op;
  } cell_ctrl_t;

endpackage

[hdl/deq_cell.sv]
// one storage cell of the deque row, with its slice of the back-read chain
module deq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDXW       = 7,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  deq_pkg::cell_ctrl_t   ctrl,
  input  logic [IDXW-1:0]       tail_idx,
  input  logic [IDXW-1:0]       back_idx,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] lower_data,
  input  logic [DATA_WIDTH-1:0] upper_data,
  input  logic [DATA_WIDTH-1:0] chain_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] chain_out
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

  // stored word: shift towards the back, towards the front, or load at the tail
  always_ff @(posedge clk) begin
    case (ctrl.op)
      deq_pkg::OP_SHIFT_UP: begin
        data <= lower_data;
      end
      deq_pkg::OP_SHIFT_DOWN: begin
        data <= upper_data;
      end
      deq_pkg::OP_LOAD: begin
        if (tail_idx == MY_IDX) begin
          data <= word;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

  // back-read chain moves one cell towards the front each cycle
  always_ff @(posedge clk) begin
    chain_out <= (back_idx == MY_IDX) ? data : chain_in;
  end

endmodule

[hdl/double_ended_queue.sv]
// double-ended queue of signed words built as a row of shifting cells
//
//  channel | direction | beat                         | handshake
//  --------+-----------+------------------------------+-----------------------
//  req     | in        | cmd, push_value              | req_valid / req_stall
//  rsp     | out       | read_value, status, count,   | rsp_valid / rsp_stall
//          |           | is_empty                     |
//
// Push, pop and peek at the front, push at the back and every failed command
// register the result beat at the accept edge. Pop and peek at the back wait
// in a busy state while the back word rides the read chain from its cell
// down to cell zero, and the result beat is registered when it arrives.
// Reset empties the queue at once; no clearing pass runs over the cells.
// A stalled result holds, and no new request is taken until it has gone.
module double_ended_queue #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);

  localparam int IDXW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int WAITW = $clog2(DEPTH + 2);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BACK = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [CNTW-1:0]       occ;
  logic [CNTW-1:0]       occ_next;
  logic [CNTW-1:0]       occ_m1;
  logic [WAITW-1:0]      wait_cnt;
  logic [WAITW-1:0]      wait_next;
  logic                  pend_pop;
  logic                  pend_next;
  logic                  load_rsp;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [CNTW+7:0]       occ_wide;
  deq_pkg::rsp_t         rsp_next;
  deq_pkg::cell_ctrl_t   ctrl;
  logic [DATA_WIDTH+31:0] push_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH+31:0] front_ext;
  logic [DATA_WIDTH+31:0] back_ext;
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_chain [DEPTH];

  // handshake on the request side
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  assign full   = (occ == CNTW'(DEPTH));
  assign empty  = (occ == '0);
  assign occ_m1 = occ - CNTW'(1);

  // word to store and words read, sign-extended then cut to the beat width
  assign push_ext  = {{DATA_WIDTH{req.push_value[31]}}, req.push_value};
  assign word      = push_ext[DATA_WIDTH-1:0];
  assign front_ext = {{32{cell_data[0][DATA_WIDTH-1]}}, cell_data[0]};
  assign back_ext  = {{32{cell_chain[0][DATA_WIDTH-1]}}, cell_chain[0]};

  // command decode and sequencing
  always_comb begin
    state_next           = state;
    occ_next             = occ;
    wait_next            = wait_cnt;
    pend_next            = pend_pop;
    ctrl.op              = deq_pkg::OP_HOLD;
    load_rsp             = 1'b0;
    rsp_next.read_value  = '0;
    rsp_next.status      = deq_pkg::ST_OK;
    if (state == S_IDLE) begin
      if (accept) begin
        load_rsp = 1'b1;
        case (req.cmd)
          deq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
              rsp_next.status = deq_pkg::ST_OVERFLOW;
            end else begin
              ctrl.op  = deq_pkg::OP_SHIFT_UP;
              occ_next = occ + CNTW'(1);
            end
          end
          deq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
              rsp_next.status = deq_pkg::ST_OVERFLOW;
            end else begin
              ctrl.op  = deq_pkg::OP_LOAD;
              occ_next = occ + CNTW'(1);
            end
          end
          deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
            if (empty) begin
              rsp_next.status = deq_pkg::ST_EMPTY;
            end else begin
              rsp_next.read_value = front_ext[31:0];
              if (req.cmd == deq_pkg::CMD_POP_FRONT) begin
                ctrl.op  = deq_pkg::OP_SHIFT_DOWN;
                occ_next = occ_m1;
              end
            end
          end
          deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
            if (empty) begin
              rsp_next.status = deq_pkg::ST_EMPTY;
            end else begin
              load_rsp   = 1'b0;
              state_next = S_BACK;
              wait_next  = WAITW'(occ) + WAITW'(1);
              pend_next  = (req.cmd == deq_pkg::CMD_POP_BACK);
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      // wait for the back word to reach the front of the chain
      wait_next = wait_cnt - WAITW'(1);
      if (wait_cnt == WAITW'(1)) begin
        load_rsp            = 1'b1;
        state_next          = S_IDLE;
        rsp_next.read_value = back_ext[31:0];
        if (pend_pop) begin
          occ_next = occ_m1;
        end
      end
    end
    occ_wide             = {8'b0, occ_next};
    rsp_next.entry_count = occ_wide[7:0];
    rsp_next.is_empty    = (occ_next == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      wait_cnt  <= '0;
      pend_pop  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      occ      <= occ_next;
      wait_cnt <= wait_next;
      pend_pop <= pend_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  // row of cells, front word in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_data;
    logic [DATA_WIDTH-1:0] upper_data;
    logic [DATA_WIDTH-1:0] chain_in;

    if (i == 0) begin : g_first
      assign lower_data = word;
    end else begin : g_lower
      assign lower_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_data = cell_data[i];
      assign chain_in   = '0;
    end else begin : g_upper
      assign upper_data = cell_data[i+1];
      assign chain_in   = cell_chain[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDXW       (IDXW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .tail_idx   (occ[IDXW-1:0]),
      .back_idx   (occ_m1[IDXW-1:0]),
      .word       (word),
      .lower_data (lower_data),
      .upper_data (upper_data),
      .chain_in   (chain_in),
      .data       (cell_data[i]),
      .chain_out  (cell_chain[i])
    );
  end

endmodule

[hdl/deq_checker.sv]
// port-level checks on the double-ended queue, bound to the top level
module deq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input deq_pkg::rsp_t rsp
);

  // a failed command never returns a word
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != deq_pkg::ST_OK) |-> (rsp.read_value == '0))
    else $error("failed command returned a word");

  // an empty flag always comes with a zero count
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> (rsp.entry_count == '0))
    else $error("empty flag with non-zero count");

  // no request is taken while a result beat is held back
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
    else $error("request taken over a stalled result");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[bench/tb_double_ended_queue.sv]
// self-checking bench for the double-ended queue: directed table, then random fill and drain sweeps
`timescale 1ns / 100ps

module tb_double_ended_queue;

  localparam int QUEUE_DEPTH   = 128;
  localparam int RANDOM_ITEMS  = 750;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 90;

  // command codes the block treats as no operation
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef enum logic {FILL_UP, DRAIN_DOWN} sweep_t;

  typedef struct packed {
    deq_pkg::req_t beat;
    bit            fixed;
    deq_pkg::rsp_t want;
  } directed_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  deq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  deq_pkg::rsp_t rsp;

  // shadow copy of the deque contents
  logic signed [31:0]              deque_words [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0]  front_slot = '0;
  logic [7:0]                      word_count = '0;

  deq_pkg::rsp_t pending_results [$];
  directed_row_t directed [$];
  int            mismatches      = 0;
  int            results_checked = 0;
  int            hold_left       = 0;
  bit            held_off        = 1'b0;
  bit            sender_steady   = 1'b0;

  double_ended_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one command against the shadow deque, giving the result it should produce
  function automatic deq_pkg::rsp_t next_deque_result(input deq_pkg::req_t beat);
    deq_pkg::rsp_t                  r;
    logic [$clog2(QUEUE_DEPTH)-1:0] slot;
    r = '0;
    r.status = deq_pkg::ST_OK;
    case (beat.cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (word_count == QUEUE_DEPTH) begin
          r.status = deq_pkg::ST_OVERFLOW;
        end else if (beat.cmd == deq_pkg::CMD_PUSH_FRONT) begin
          front_slot = front_slot - 1'b1;
          deque_words[front_slot] = beat.push_value;
          word_count++;
        end else begin
          slot = front_slot + word_count[$clog2(QUEUE_DEPTH)-1:0];
          deque_words[slot] = beat.push_value;
          word_count++;
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
        if (word_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          r.read_value = deque_words[front_slot];
          if (beat.cmd == deq_pkg::CMD_POP_FRONT) begin
            front_slot = front_slot + 1'b1;
            word_count--;
          end
        end
      end
      deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
        if (word_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          slot = front_slot + word_count[$clog2(QUEUE_DEPTH)-1:0] - 1'b1;
          r.read_value = deque_words[slot];
          if (beat.cmd == deq_pkg::CMD_POP_BACK) word_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = word_count;
    r.is_empty    = (word_count == 0);
    return r;
  endfunction

  function automatic directed_row_t row(input logic [2:0] c, input logic [31:0] v,
                                        input bit fixed = 1'b0, input logic [31:0] rd = '0,
                                        input logic [1:0] st = deq_pkg::ST_OK,
                                        input logic [7:0] cnt = '0, input logic e = 1'b0);
    directed_row_t d;
    d.beat.cmd          = c;
    d.beat.push_value   = v;
    d.fixed             = fixed;
    d.want.read_value   = rd;
    d.want.status       = st;
    d.want.entry_count  = cnt;
    d.want.is_empty     = e;
    return d;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input directed_row_t d);
    directed.insert(directed.size(), d);
  endfunction

  // data words lean towards the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // filling sweeps mostly push, draining sweeps mostly pop
  function automatic deq_pkg::req_t random_beat(input sweep_t sweep);
    deq_pkg::req_t b;
    int unsigned   roll;
    roll = $urandom_range(99);
    b.push_value = pick_word();
    if (roll < 4)
      b.cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
    else if (roll < 84 && sweep == FILL_UP)
      b.cmd = $urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
    else if (roll < 84)
      b.cmd = $urandom_range(1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
    else if (roll < 94)
      b.cmd = $urandom_range(1) ? deq_pkg::CMD_PEEK_FRONT : deq_pkg::CMD_PEEK_BACK;
    else if (sweep == FILL_UP)
      b.cmd = $urandom_range(1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
    else
      b.cmd = $urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
    return b;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input deq_pkg::rsp_t got);
    deq_pkg::rsp_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_results[0];
    pending_results.delete(0);
    flag_field("read_value", want.read_value, got.read_value);
    flag_field("status", want.status, got.status);
    flag_field("entry_count", want.entry_count, got.entry_count);
    flag_field("is_empty", want.is_empty, got.is_empty);
  endtask

  // offer one request beat, with random gaps ahead of it, and log its result
  task automatic offer(input deq_pkg::req_t beat, input bit fixed, input deq_pkg::rsp_t want,
                       output deq_pkg::rsp_t predicted);
    while (!sender_steady && $urandom_range(99) < 16) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = next_deque_result(beat);
    pending_results.insert(pending_results.size(), fixed ? want : predicted);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result side: checks, random stalls, one long hold-off, one stall-free window
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        check_result(rsp);
        results_checked++;
      end
      if (!held_off && results_checked == 300) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (results_checked >= 550 && results_checked < 650) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 16);
      end
    end
  end

  // request side
  initial begin
    deq_pkg::rsp_t got;
    deq_pkg::req_t beat;
    sweep_t        sweep;
    int            edge_hits;
    int            n;

    // empty queue, extremes at both ends, spare codes, then a short mixed run
    add_row(row(deq_pkg::CMD_PEEK_FRONT, 32'h0, 1, 32'h0, deq_pkg::ST_EMPTY, 8'd0, 1'b1));
    add_row(row(deq_pkg::CMD_POP_BACK, 32'h1234_5678, 1, 32'h0, deq_pkg::ST_EMPTY, 8'd0,
                1'b1));
    add_row(row(deq_pkg::CMD_POP_FRONT, 32'h0, 1, 32'h0, deq_pkg::ST_EMPTY, 8'd0, 1'b1));
    add_row(row(deq_pkg::CMD_PEEK_BACK, 32'h0, 1, 32'h0, deq_pkg::ST_EMPTY, 8'd0, 1'b1));
    add_row(row(CMD_SPARE_6, 32'hffff_ffff, 1, 32'h0, deq_pkg::ST_OK, 8'd0, 1'b1));
    add_row(row(deq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff, 1, 32'h0, deq_pkg::ST_OK, 8'd1,
                1'b0));
    add_row(row(deq_pkg::CMD_PUSH_BACK, 32'h8000_0000, 1, 32'h0, deq_pkg::ST_OK, 8'd2,
                1'b0));
    add_row(row(deq_pkg::CMD_PEEK_FRONT, 32'h0, 1, 32'h7fff_ffff, deq_pkg::ST_OK, 8'd2,
                1'b0));
    add_row(row(deq_pkg::CMD_PEEK_BACK, 32'h0, 1, 32'h8000_0000, deq_pkg::ST_OK, 8'd2,
                1'b0));
    add_row(row(CMD_SPARE_7, 32'hffff_ffff, 1, 32'h0, deq_pkg::ST_OK, 8'd2, 1'b0));
    add_row(row(deq_pkg::CMD_POP_FRONT, 32'h0, 1, 32'h7fff_ffff, deq_pkg::ST_OK, 8'd1,
                1'b0));
    add_row(row(deq_pkg::CMD_POP_BACK, 32'h0, 1, 32'h8000_0000, deq_pkg::ST_OK, 8'd0,
                1'b1));
    add_row(row(deq_pkg::CMD_POP_BACK, 32'h0, 1, 32'h0, deq_pkg::ST_EMPTY, 8'd0, 1'b1));
    add_row(row(deq_pkg::CMD_PUSH_BACK, 32'h0000_0000));
    add_row(row(deq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff));
    add_row(row(deq_pkg::CMD_PUSH_BACK, 32'h5555_5555));
    add_row(row(deq_pkg::CMD_PUSH_FRONT, 32'haaaa_aaaa));
    add_row(row(deq_pkg::CMD_PEEK_BACK, 32'h0));
    add_row(row(deq_pkg::CMD_POP_BACK, 32'h0));
    add_row(row(deq_pkg::CMD_PEEK_FRONT, 32'h0));
    add_row(row(deq_pkg::CMD_POP_FRONT, 32'h0));
    add_row(row(deq_pkg::CMD_POP_FRONT, 32'h0));
    add_row(row(deq_pkg::CMD_POP_BACK, 32'h0));
    add_row(row(deq_pkg::CMD_PEEK_BACK, 32'h0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) offer(directed[i].beat, directed[i].fixed, directed[i].want, got);
    wait_drained();

    // random sweeps: fill until overflow shows up four times, drain until underflow shows up three times
    sweep     = FILL_UP;
    edge_hits = 0;
    n         = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == 400) wait_drained();
      sender_steady = (n >= 500 && n < 600);
      beat = random_beat(sweep);
      offer(beat, 1'b0, '0, got);
      if (beat.cmd != CMD_SPARE_6 && beat.cmd != CMD_SPARE_7) n++;
      if (sweep == FILL_UP && got.status == deq_pkg::ST_OVERFLOW && ++edge_hits >= 4) begin
        sweep     = DRAIN_DOWN;
        edge_hits = 0;
      end else if (sweep == DRAIN_DOWN && got.status == deq_pkg::ST_EMPTY &&
                   ++edge_hits >= 3) begin
        sweep     = FILL_UP;
        edge_hits = 0;
      end
    end

    // let the last results through, then allow for the slowest back access
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("double_ended_queue verification clean");
    else
      $display("double_ended_queue verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("double_ended_queue verification failed");
    $finish;
  end

endmodule
